FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers. They expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define RPS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition must never be true at a clock edge outside reset.
`define RPS_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define RPS_ASSERT(label, clk, rst_n, prop, msg)
`define RPS_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

FILE: rtl/rps_pkg.sv
// ----------------------------------------------------------------------------
// Random permutation shuffler package
// Widths, result kinds and the command and status bundles shared by the
// controller and the datapath.
// ----------------------------------------------------------------------------
package rps_pkg;

  // Default permutation size limit.
  localparam int MAX_ELEMENTS_DEF = 64;

  // Field widths.
  localparam int CNT_W       = 7;
  localparam int VAL_W       = 6;
  localparam int WORD_W      = 32;
  localparam int KIND_W      = 3;
  localparam int TDATA_OUT_W = 8;

  // The divider walks the 33-bit dividend 2^32 one bit per cycle.
  localparam int DIV_STEPS = WORD_W + 1;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // Reset value of the element count register.
  localparam logic [CNT_W-1:0] CNT_RESET = 7'd64;

  // Result kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_STARTED  = 3'd0,
    KIND_REJECTED = 3'd1,
    KIND_ACCEPTED = 3'd2,
    KIND_ELEMENT  = 3'd3,
    KIND_IDLE     = 3'd4
  } kind_e;

  // Input opcodes.
  typedef enum logic {
    OP_START = 1'b0,
    OP_DRAW  = 1'b1
  } opcode_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  start;
    logic  init_wr;
    logic  idx_clr;
    logic  load_word;
    logic  div_step;
    logic  rd_top;
    logic  rd_j;
    logic  wr_top;
    logic  wr_j;
    logic  emit_rd;
    logic  emit_out;
    logic  out_load;
    kind_e out_kind;
  } rps_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic n_is_one;
    logic idx_last;
    logic div_last;
    logic reject;
    logic pos_is_two;
    logic out_free;
  } rps_stat_t;

endpackage

FILE: rtl/rps_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module rps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/rps_ctrl.sv
// ----------------------------------------------------------------------------
// Shuffler controller
// Sequences start-up fill, draw division, swap and element readout.
// ----------------------------------------------------------------------------
module rps_ctrl import rps_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_opcode_i,
  input  rps_stat_t stat_i,
  output logic      in_ready_o,
  output rps_cmd_t  cmd_o
);

  typedef enum logic [9:0] {
    ST_IDLE     = 10'b00_0000_0001,
    ST_INIT     = 10'b00_0000_0010,
    ST_DIV      = 10'b00_0000_0100,
    ST_DECIDE   = 10'b00_0000_1000,
    ST_RD_J     = 10'b00_0001_0000,
    ST_WR_TOP   = 10'b00_0010_0000,
    ST_WR_J     = 10'b00_0100_0000,
    ST_EMIT_RD  = 10'b00_1000_0000,
    ST_EMIT_OUT = 10'b01_0000_0000,
    ST_RESP     = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   busy_q, busy_d;
  kind_e  kind_q, kind_d;

  // Next-state and command decode.
  always_comb begin
    state_d        = state_q;
    busy_d         = busy_q;
    kind_d         = kind_q;
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    cmd_o.out_kind = kind_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_opcode_i == OP_START) begin
            cmd_o.start = 1'b1;
            state_d     = ST_INIT;
          end else if (busy_q) begin
            cmd_o.load_word = 1'b1;
            state_d         = ST_DIV;
          end else begin
            kind_d  = KIND_IDLE;
            state_d = ST_RESP;
          end
        end
      end
      ST_INIT: begin
        cmd_o.init_wr = 1'b1;
        if (stat_i.idx_last) begin
          cmd_o.idx_clr = 1'b1;
          if (stat_i.n_is_one) begin
            busy_d  = 1'b0;
            state_d = ST_EMIT_RD;
          end else begin
            busy_d  = 1'b1;
            kind_d  = KIND_STARTED;
            state_d = ST_RESP;
          end
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (stat_i.reject) begin
          kind_d  = KIND_REJECTED;
          state_d = ST_RESP;
        end else begin
          cmd_o.rd_top = 1'b1;
          state_d      = ST_RD_J;
        end
      end
      ST_RD_J: begin
        cmd_o.rd_j = 1'b1;
        state_d    = ST_WR_TOP;
      end
      ST_WR_TOP: begin
        cmd_o.wr_top = 1'b1;
        state_d      = ST_WR_J;
      end
      ST_WR_J: begin
        cmd_o.wr_j = 1'b1;
        if (stat_i.pos_is_two) begin
          busy_d        = 1'b0;
          cmd_o.idx_clr = 1'b1;
          state_d       = ST_EMIT_RD;
        end else begin
          kind_d  = KIND_ACCEPTED;
          state_d = ST_RESP;
        end
      end
      ST_EMIT_RD: begin
        cmd_o.emit_rd = 1'b1;
        state_d       = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.emit_out = 1'b1;
          state_d        = stat_i.idx_last ? ST_IDLE : ST_EMIT_RD;
        end
      end
      ST_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
      kind_q  <= KIND_STARTED;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
      kind_q  <= kind_d;
    end
  end

endmodule

FILE: rtl/rps_dpath.sv
// ----------------------------------------------------------------------------
// Shuffler datapath
// Count register, bit-serial divider, permutation store and output register.
// ----------------------------------------------------------------------------
module rps_dpath import rps_pkg::*; #(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CNT_W-1:0]  cfg_wdata_i,
  input  logic [WORD_W-1:0] word_i,
  input  rps_cmd_t          cmd_i,
  output rps_stat_t         stat_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [KIND_W-1:0] out_kind_o,
  output logic [VAL_W-1:0]  out_value_o,
  output logic              out_last_o
);

  localparam int               IDX_W   = $clog2(MAX_ELEMENTS);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ELEMENTS);

  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  n_q;
  logic [CNT_W-1:0]  pos_q;
  logic [CNT_W-1:0]  idx_q;
  logic [STEP_W-1:0] step_q;
  logic [WORD_W-1:0] word_q;
  logic [WORD_W:0]   sh_q;
  logic [CNT_W-1:0]  rem_w_q, rem_w_d;
  logic [CNT_W-1:0]  rem_m_q, rem_m_d;
  logic [VAL_W-1:0]  tmp_q;
  logic              out_valid_q;
  logic [KIND_W-1:0] out_kind_q;
  logic [VAL_W-1:0]  out_value_q;
  logic              out_last_q;

  logic [CNT_W-1:0]  n_clamp;
  logic [CNT_W:0]    pos_ext, tw, tm;
  logic [WORD_W:0]   sum;
  logic [CNT_W-1:0]  top_full;
  logic [IDX_W-1:0]  top_addr, j_addr, idx_addr;
  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [VAL_W-1:0]  ram_wdata, ram_rdata;
  logic              out_load;

  // Run length taken from the count register, held to 1..MAX_ELEMENTS.
  assign n_clamp = (count_q == '0) ? CNT_W'(1) :
                   ((count_q > MAX_CNT) ? MAX_CNT : count_q);

  // One restoring division step on the draw and on 2^32 in parallel.
  assign pos_ext = {1'b0, pos_q};
  assign tw      = {rem_w_q, sh_q[WORD_W]};
  assign tm      = {rem_m_q, (step_q == '0)};
  assign rem_w_d = (tw >= pos_ext) ? CNT_W'(tw - pos_ext) : tw[CNT_W-1:0];
  assign rem_m_d = (tm >= pos_ext) ? CNT_W'(tm - pos_ext) : tm[CNT_W-1:0];

  // A draw is biased exactly when draw + (2^32 mod position) carries out.
  assign sum = {1'b0, word_q} + (WORD_W+1)'(rem_m_q);

  // Store addresses.
  assign top_full = pos_q - CNT_W'(1);
  assign top_addr = top_full[IDX_W-1:0];
  assign j_addr   = rem_w_q[IDX_W-1:0];
  assign idx_addr = idx_q[IDX_W-1:0];

  // Store port selection.
  always_comb begin
    ram_we    = cmd_i.init_wr | cmd_i.wr_top | cmd_i.wr_j;
    ram_re    = cmd_i.rd_top | cmd_i.rd_j | cmd_i.emit_rd;
    ram_waddr = idx_addr;
    ram_wdata = idx_q[VAL_W-1:0];
    if (cmd_i.wr_top) begin
      ram_waddr = top_addr;
      ram_wdata = ram_rdata;
    end else if (cmd_i.wr_j) begin
      ram_waddr = j_addr;
      ram_wdata = tmp_q;
    end
    ram_raddr = idx_addr;
    if (cmd_i.rd_top) begin
      ram_raddr = top_addr;
    end else if (cmd_i.rd_j) begin
      ram_raddr = j_addr;
    end
  end

  rps_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_ELEMENTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Status toward the controller.
  always_comb begin
    stat_o.n_is_one   = (n_q == CNT_W'(1));
    stat_o.idx_last   = (idx_q == n_q - CNT_W'(1));
    stat_o.div_last   = (step_q == STEP_W'(DIV_STEPS - 1));
    stat_o.reject     = sum[WORD_W];
    stat_o.pos_is_two = (pos_q == CNT_W'(2));
    stat_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_load = cmd_i.out_load | cmd_i.emit_out;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= CNT_RESET;
      n_q         <= '0;
      pos_q       <= '0;
      idx_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
      if (cmd_i.start) begin
        n_q   <= n_clamp;
        pos_q <= n_clamp;
      end else if (cmd_i.wr_j) begin
        pos_q <= pos_q - CNT_W'(1);
      end
      if (cmd_i.start || cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.init_wr || cmd_i.emit_out) begin
        idx_q <= idx_q + CNT_W'(1);
      end
      if (cmd_i.load_word) begin
        step_q <= '0;
      end else if (cmd_i.div_step) begin
        step_q <= step_q + STEP_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_word) begin
      word_q  <= word_i;
      sh_q    <= {1'b0, word_i};
      rem_w_q <= '0;
      rem_m_q <= '0;
    end else if (cmd_i.div_step) begin
      sh_q    <= {sh_q[WORD_W-1:0], 1'b0};
      rem_w_q <= rem_w_d;
      rem_m_q <= rem_m_d;
    end
    if (cmd_i.rd_j) begin
      tmp_q <= ram_rdata;
    end
    if (cmd_i.emit_out) begin
      out_kind_q  <= KIND_ELEMENT;
      out_value_q <= ram_rdata;
      out_last_q  <= stat_o.idx_last;
    end else if (cmd_i.out_load) begin
      out_kind_q  <= cmd_i.out_kind;
      out_value_q <= '0;
      out_last_q  <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_value_o = out_value_q;
  assign out_last_o  = out_last_q;

endmodule

FILE: rtl/random_permutation_shuffler.sv
// Start: fills the store with the identity, then one "started" word (n = 1 gives the element).
// Draw: bit-serial divider, then a decide step; a rejected draw gives one word, else swap, then one word.
// Final draw: n element words, each read from the store's registered read, then sent once the output is free.
// A new item is taken only in idle; a waiting result word does not block it.
// Reset (rst_ni low, asynchronous) clears control, sets element_count to 64.
// The permutation store is not cleared; every run fills it before reading.
// ----------------------------------------------------------------------------
// Random permutation shuffler
// Fisher-Yates shuffle with rejection sampling, as controller and datapath.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module random_permutation_shuffler import rps_pkg::*; #(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CNT_W-1:0]       cfg_wdata_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [WORD_W-1:0]      s_axis_tdata,  // [31:0] random_word
  input  logic [0:0]             s_axis_tuser,  // [0] opcode
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [TDATA_OUT_W-1:0] m_axis_tdata,  // [5:0] element_value, [7:6] zero
  output logic [KIND_W-1:0]      m_axis_tuser,  // [2:0] kind
  output logic                   m_axis_tlast
);

  rps_cmd_t         cmd;
  rps_stat_t        stat;
  logic [VAL_W-1:0] value;

  // Sequencer.
  rps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_opcode_i (s_axis_tuser[0]),
    .stat_i      (stat),
    .in_ready_o  (s_axis_tready),
    .cmd_o       (cmd)
  );

  // Storage, divider and result register.
  rps_dpath #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .word_i      (s_axis_tdata),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_kind_o  (m_axis_tuser),
    .out_value_o (value),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {{(TDATA_OUT_W - VAL_W){1'b0}}, value};

  // A store write never happens while the sequencer is taking items.
  `RPS_ASSERT_NEVER(a_no_wr_in_idle, clk_i, rst_ni, s_axis_tready && (cmd.init_wr || cmd.wr_top || cmd.wr_j), "store written while idle")
  // A result word is loaded only into a free output register.
  `RPS_ASSERT(a_out_free, clk_i, rst_ni, (cmd.out_load || cmd.emit_out) |-> (!m_axis_tvalid || m_axis_tready), "result word overwritten")
  // After an accepted start, no item is taken while the store is being filled.
  `RPS_ASSERT(a_start_fill, clk_i, rst_ni, (s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == OP_START) |=> !s_axis_tready, "start did not fill")

endmodule
